### sv/dqap_pkg.sv
// ----------------------------------------------------------------------------
// dqap_pkg
// Shared types, character codes and digit helpers for the dotted-quad
// address parser.
// ----------------------------------------------------------------------------
package dqap_pkg;

	typedef logic [7:0]  char_t;
	typedef logic [31:0] addr_t;
	typedef logic [8:0]  part_t;

	// Radix of a digit being folded into the current part
	typedef enum logic [1:0] {
		RADIX_OCT,
		RADIX_DEC,
		RADIX_HEX
	} radix_t;

	localparam char_t CH_NUL   = 8'h00;
	localparam char_t CH_DOT   = 8'h2E;
	localparam char_t CH_PLUS  = 8'h2B;
	localparam char_t CH_MINUS = 8'h2D;
	localparam char_t CH_SPACE = 8'h20;
	localparam char_t CH_TAB   = 8'h09;
	localparam char_t CH_CR    = 8'h0D;
	localparam char_t CH_ZERO  = 8'h30;
	localparam char_t CH_ONE   = 8'h31;
	localparam char_t CH_SEVEN = 8'h37;
	localparam char_t CH_NINE  = 8'h39;
	localparam char_t CH_LA    = 8'h61;
	localparam char_t CH_LF    = 8'h66;
	localparam char_t CH_UA    = 8'h41;
	localparam char_t CH_UF    = 8'h46;
	localparam char_t CH_LX    = 8'h78;
	localparam char_t CH_UX    = 8'h58;

	localparam part_t PART_MAX    = 9'd255;
	localparam part_t PART_CLAMP  = 9'd256;
	localparam logic [2:0] LAST_DOT = 3'd3;

	function automatic logic is_blank(input char_t c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic is_dec(input char_t c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_oct(input char_t c);
		return (c >= CH_ZERO) && (c <= CH_SEVEN);
	endfunction

	function automatic logic is_hex(input char_t c);
		return is_dec(c) || (c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF);
	endfunction

	// Digit value of a hex/decimal/octal character (valid only if is_hex)
	function automatic logic [3:0] digit_val(input char_t c);
		char_t t;
		t = 8'h00;
		if (is_dec(c)) begin
			t = c - CH_ZERO;
		end else if (c >= CH_LA && c <= CH_LF) begin
			t = c - CH_LA + 8'd10;
		end else begin
			t = c - CH_UA + 8'd10;
		end
		return t[3:0];
	endfunction

	// part * radix + digit, held at 256 once it passes 255
	function automatic part_t add_digit(input part_t pv, input radix_t r,
			input logic [3:0] d);
		logic [13:0] v;
		logic [13:0] p;
		p = {5'd0, pv};
		unique case (r)
			RADIX_OCT: v = (p << 3) + {10'd0, d};
			RADIX_DEC: v = (p << 3) + (p << 1) + {10'd0, d};
			RADIX_HEX: v = (p << 4) + {10'd0, d};
			default:   v = 14'd0;
		endcase
		return (v > 14'(PART_CLAMP)) ? PART_CLAMP : v[8:0];
	endfunction

endpackage

### sv/dotted_quad_address_parser.sv
// ----------------------------------------------------------------------------
// dotted_quad_address_parser
// Parses an IPv4 address written as text, one character per word, and
// returns the packed address (or a rejection) at the terminating zero byte.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle, except that a zero byte waits while an
// earlier result is held by a receiver stall. The parse state updates from the
// input register, and a zero byte's result is registered in the result
// register when the byte leaves the input register.
// Reset: arst_n clears the input and result valid flags and the parse state
// (start of a new string); no clearing pass is needed.
module dotted_quad_address_parser (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            ch_valid,
	output logic            ch_stall,
	input  dqap_pkg::char_t ch,
	output logic            res_valid,
	input  logic            res_stall,
	output logic            accepted,
	output dqap_pkg::addr_t address
);
	import dqap_pkg::*;

	// Position within the current part
	typedef enum logic [2:0] {
		PH_START,
		PH_BLANKS,
		PH_SIGNED,
		PH_ZERO,
		PH_XPEND,
		PH_DEC,
		PH_OCT,
		PH_HEX
	} phase_t;

	// Input register
	logic  vld_s1;
	char_t ch_s1;

	// Parse state
	part_t      part_q;
	phase_t     phase_q;
	logic [2:0] parts_q;
	addr_t      addr_q;
	logic       rej_q;
	logic       minus_q;
	logic       empty_q;

	// Next state
	part_t      part_d;
	phase_t     phase_d;
	logic [2:0] parts_d;
	addr_t      addr_d;
	logic       rej_d;
	logic       minus_d;
	logic       empty_d;

	logic  adv_s1;
	logic  is_end;
	logic  close_ok;
	addr_t addr_closed;
	logic  res_ok;

	// Stage 1 advances unless a zero byte waits for a busy result register
	assign is_end   = (ch_s1 == CH_NUL);
	assign adv_s1   = vld_s1 && (!is_end || !res_valid || !res_stall);
	assign ch_stall = vld_s1 && !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!ch_stall) begin
			vld_s1 <= ch_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!ch_stall && ch_valid) begin
			ch_s1 <= ch;
		end
	end

	// Can the current part end here
	assign close_ok = (phase_q != PH_BLANKS) && (phase_q != PH_SIGNED) &&
		(phase_q != PH_XPEND) && (part_q <= PART_MAX) &&
		!(minus_q && (part_q != 9'd0));
	assign addr_closed = {addr_q[23:0], part_q[7:0]};
	assign res_ok = !rej_q && !empty_q && close_ok;

	// Character step
	always_comb begin
		part_d  = part_q;
		phase_d = phase_q;
		parts_d = parts_q;
		addr_d  = addr_q;
		rej_d   = rej_q;
		minus_d = minus_q;
		empty_d = empty_q;
		if (is_end) begin
			part_d  = 9'd0;
			phase_d = PH_START;
			parts_d = 3'd0;
			addr_d  = '0;
			rej_d   = 1'b0;
			minus_d = 1'b0;
			empty_d = 1'b1;
		end else begin
			empty_d = 1'b0;
			if (!rej_q) begin
				if (ch_s1 == CH_DOT) begin
					if (!close_ok || parts_q >= LAST_DOT) begin
						rej_d = 1'b1;
					end else begin
						parts_d = parts_q + 3'd1;
						addr_d  = addr_closed;
						part_d  = 9'd0;
						phase_d = PH_START;
						minus_d = 1'b0;
					end
				end else begin
					unique case (phase_q)
						PH_START, PH_BLANKS, PH_SIGNED: begin
							if (phase_q != PH_SIGNED && is_blank(ch_s1)) begin
								phase_d = PH_BLANKS;
							end else if (phase_q != PH_SIGNED &&
									(ch_s1 == CH_PLUS || ch_s1 == CH_MINUS)) begin
								minus_d = (ch_s1 == CH_MINUS);
								phase_d = PH_SIGNED;
							end else if (ch_s1 == CH_ZERO) begin
								phase_d = PH_ZERO;
							end else if (ch_s1 >= CH_ONE && ch_s1 <= CH_NINE) begin
								part_d  = add_digit(part_q, RADIX_DEC, digit_val(ch_s1));
								phase_d = PH_DEC;
							end else begin
								rej_d = 1'b1;
							end
						end
						PH_ZERO: begin
							if (ch_s1 == CH_LX || ch_s1 == CH_UX) begin
								phase_d = PH_XPEND;
							end else if (is_oct(ch_s1)) begin
								part_d  = add_digit(part_q, RADIX_OCT, digit_val(ch_s1));
								phase_d = PH_OCT;
							end else begin
								rej_d = 1'b1;
							end
						end
						PH_XPEND, PH_HEX: begin
							if (is_hex(ch_s1)) begin
								part_d  = add_digit(part_q, RADIX_HEX, digit_val(ch_s1));
								phase_d = PH_HEX;
							end else begin
								rej_d = 1'b1;
							end
						end
						PH_DEC: begin
							if (is_dec(ch_s1)) begin
								part_d = add_digit(part_q, RADIX_DEC, digit_val(ch_s1));
							end else begin
								rej_d = 1'b1;
							end
						end
						PH_OCT: begin
							if (is_oct(ch_s1)) begin
								part_d = add_digit(part_q, RADIX_OCT, digit_val(ch_s1));
							end else begin
								rej_d = 1'b1;
							end
						end
						default: begin
							rej_d = 1'b1;
						end
					endcase
				end
			end
		end
	end

	// Parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_q  <= 9'd0;
			phase_q <= PH_START;
			parts_q <= 3'd0;
			addr_q  <= '0;
			rej_q   <= 1'b0;
			minus_q <= 1'b0;
			empty_q <= 1'b1;
		end else if (adv_s1) begin
			part_q  <= part_d;
			phase_q <= phase_d;
			parts_q <= parts_d;
			addr_q  <= addr_d;
			rej_q   <= rej_d;
			minus_q <= minus_d;
			empty_q <= empty_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (adv_s1 && is_end) begin
			res_valid <= 1'b1;
		end else if (!res_stall) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && is_end) begin
			accepted <= res_ok;
			address  <= res_ok ? addr_closed : '1;
		end
	end

endmodule

### verif/tb_dotted_quad_address_parser.sv
// ----------------------------------------------------------------------------
// tb_dotted_quad_address_parser
// Streams address strings into the parser one character per word and checks
// every parse result against a cycle-free predictor. Strings are mostly
// well-formed dotted quads in decimal, octal and hex with random blanks,
// signs and sizes, plus corrupted and pure-noise strings. The run goes
// through four handshake phases with different sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_dotted_quad_address_parser;
	timeunit 1ns;
	timeprecision 1ps;

	import dqap_pkg::*;

	localparam int unsigned PHASE_CHARS = 465;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned DRAIN_CYCLES = 16;

	// Position of the predictor within the current part
	typedef enum logic [2:0] {
		P_START,
		P_BLANKS,
		P_SIGNED,
		P_ZERO,
		P_XPEND,
		P_DEC,
		P_OCT,
		P_HEX
	} part_phase_t;

	typedef struct packed {
		logic  ok;
		addr_t addr;
	} parse_result_t;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  ch_valid = 1'b0;
	logic  ch_stall;
	char_t ch = CH_NUL;
	logic  res_valid;
	logic  res_stall = 1'b0;
	logic  accepted;
	addr_t address;

	dotted_quad_address_parser dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.ch_valid (ch_valid),
		.ch_stall (ch_stall),
		.ch       (ch),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.accepted (accepted),
		.address  (address)
	);

	// Characters waiting to be sent and parse results waiting to arrive
	char_t         char_q[$];
	parse_result_t parse_q[$];

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned cycle_cnt = 0;
	int unsigned errors = 0;
	int unsigned n_chars = 0;
	int unsigned n_strings = 0;
	int unsigned n_ok = 0;
	int unsigned n_bad = 0;

	// Predictor state for the string being parsed
	part_t       part_val;
	part_phase_t part_phase;
	logic [2:0]  dots_seen;
	addr_t       addr_acc;
	bit          str_rejected;
	bit          part_minus;
	bit          str_empty;

	parse_result_t want;

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
	end

	initial begin
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d results still pending",
			cycle_cnt, parse_q.size());
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic report_mismatch(input string what);
		errors++;
		$display("mismatch at %0t: %s", $realtime, what);
	endtask

	// ---------------------------------------------------------------- predictor

	function automatic void start_part();
		part_val = '0;
		part_phase = P_START;
		part_minus = 1'b0;
	endfunction

	function automatic void clear_string();
		start_part();
		dots_seen = '0;
		addr_acc = '0;
		str_rejected = 1'b0;
		str_empty = 1'b1;
	endfunction

	function automatic int hex_digit(input char_t c);
		if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
		if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
		if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
		return -1;
	endfunction

	// Fold one digit in, saturating at one above the byte range
	function automatic void grow(input int radix, input int d);
		int v;
		v = int'(part_val) * radix + d;
		part_val = (v > int'(PART_CLAMP)) ? PART_CLAMP : part_t'(v);
	endfunction

	// First digit of a part picks decimal, or a leading zero for octal or hex
	function automatic void lead_digit(input char_t c);
		if (c == CH_ZERO) begin
			part_phase = P_ZERO;
		end else if (c >= CH_ONE && c <= CH_NINE) begin
			grow(10, int'(c - CH_ZERO));
			part_phase = P_DEC;
		end else begin
			str_rejected = 1'b1;
		end
	endfunction

	// Close the current part; false if it cannot end here or is out of range
	function automatic bit close_part();
		if (part_phase inside {P_BLANKS, P_SIGNED, P_XPEND}) return 1'b0;
		if (part_val > PART_MAX) return 1'b0;
		if (part_minus && part_val != '0) return 1'b0;
		addr_acc = {addr_acc[23:0], part_val[7:0]};
		return 1'b1;
	endfunction

	task automatic fold_char(input char_t c);
		bit ok;
		int dv;
		if (c == CH_NUL) begin
			ok = !str_rejected && !str_empty && close_part();
			parse_q.push_back('{ok: ok, addr: ok ? addr_acc : '1});
			clear_string();
			return;
		end
		str_empty = 1'b0;
		if (str_rejected) return;
		if (c == CH_DOT) begin
			if (!close_part() || dots_seen >= LAST_DOT) begin
				str_rejected = 1'b1;
			end else begin
				dots_seen++;
				start_part();
			end
			return;
		end
		dv = hex_digit(c);
		case (part_phase)
			P_START, P_BLANKS: begin
				if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
					part_phase = P_BLANKS;
				end else if (c == CH_PLUS || c == CH_MINUS) begin
					part_minus = (c == CH_MINUS);
					part_phase = P_SIGNED;
				end else begin
					lead_digit(c);
				end
			end
			P_SIGNED: lead_digit(c);
			P_ZERO: begin
				if (c == CH_LX || c == CH_UX) begin
					part_phase = P_XPEND;
				end else if (c >= CH_ZERO && c <= CH_SEVEN) begin
					grow(8, dv);
					part_phase = P_OCT;
				end else begin
					str_rejected = 1'b1;
				end
			end
			P_XPEND, P_HEX: begin
				if (dv >= 0) begin
					grow(16, dv);
					part_phase = P_HEX;
				end else begin
					str_rejected = 1'b1;
				end
			end
			P_DEC: begin
				if (c >= CH_ZERO && c <= CH_NINE) grow(10, dv);
				else str_rejected = 1'b1;
			end
			default: begin
				if (c >= CH_ZERO && c <= CH_SEVEN) grow(8, dv);
				else str_rejected = 1'b1;
			end
		endcase
	endtask

	// ------------------------------------------------------------ driver side

	// Send the next character, idling at random; hold the word while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_valid <= 1'b0;
			ch <= CH_NUL;
			clear_string();
		end else begin
			if (ch_valid && !ch_stall) fold_char(ch);
			if (!ch_valid || !ch_stall) begin
				if (char_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					ch <= char_q.pop_front();
					ch_valid <= 1'b1;
				end else begin
					ch_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver stall, drawn fresh every cycle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			res_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	// ----------------------------------------------------------- monitor side

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (parse_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result accepted=%0b address=%h",
					accepted, address));
			end else begin
				want = parse_q.pop_front();
				if (accepted !== want.ok)
					report_mismatch($sformatf("accepted=%0b, predicted %0b",
						accepted, want.ok));
				if (address !== want.addr)
					report_mismatch($sformatf("address=%h, predicted %h",
						address, want.addr));
				if (want.ok) n_ok++;
				else n_bad++;
			end
		end
	end

	// -------------------------------------------------------------- stimulus

	task automatic push_string(ref char_t s[$]);
		foreach (s[i]) char_q.push_back(s[i]);
		char_q.push_back(CH_NUL);
		n_chars += s.size() + 1;
		n_strings++;
	endtask

	task automatic load_text(input string txt);
		char_t s[$];
		for (int i = 0; i < txt.len(); i++) s.push_back(char_t'(txt[i]));
		push_string(s);
	endtask

	// Digits of v in the given radix, hex letters in random case
	task automatic put_number(ref char_t s[$], input int unsigned v,
			input int unsigned radix);
		char_t       digs[$];
		int unsigned d;
		do begin
			d = v % radix;
			if (d < 10) digs.push_front(char_t'(CH_ZERO + d));
			else if ($urandom_range(0, 1)) digs.push_front(char_t'(CH_LA + d - 10));
			else digs.push_front(char_t'(CH_UA + d - 10));
			v = v / radix;
		end while (v != 0);
		foreach (digs[i]) s.push_back(digs[i]);
	endtask

	// One random string: mostly dotted parts, sometimes damaged or pure noise
	task automatic emit_string();
		char_t       s[$];
		int unsigned nparts;
		int unsigned v;
		int unsigned pos;
		char_t       junk;
		bit          minus;
		if ($urandom_range(0, 11) == 0) begin
			repeat ($urandom_range(0, 6)) s.push_back(char_t'($urandom_range(1, 255)));
			push_string(s);
			return;
		end
		nparts = ($urandom_range(0, 19) == 0) ? 5 : $urandom_range(1, 4);
		for (int p = 0; p < nparts; p++) begin
			if (p > 0) s.push_back(CH_DOT);
			if ($urandom_range(0, 11) == 0) continue;
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(1, 2)) begin
					if ($urandom_range(0, 1)) s.push_back(CH_SPACE);
					else s.push_back(char_t'(CH_TAB + $urandom_range(0, 4)));
				end
			end
			minus = 1'b0;
			case ($urandom_range(0, 9))
				0: s.push_back(CH_PLUS);
				1: begin
					s.push_back(CH_MINUS);
					minus = 1'b1;
				end
				default: ;
			endcase
			if ($urandom_range(0, 14) == 0) continue;
			case ($urandom_range(0, 9))
				0: v = $urandom_range(256, 300);
				1: v = $urandom_range(0, 70000);
				default: v = $urandom_range(0, 255);
			endcase
			if (minus && $urandom_range(0, 2) != 0) v = 0;
			case ($urandom_range(0, 2))
				0: begin
					s.push_back(CH_ZERO);
					if (v != 0 || $urandom_range(0, 1)) put_number(s, v, 8);
				end
				1: begin
					s.push_back(CH_ZERO);
					s.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
					if ($urandom_range(0, 9) != 0) begin
						if ($urandom_range(0, 4) == 0) s.push_back(CH_ZERO);
						put_number(s, v, 16);
					end
				end
				default: put_number(s, v, 10);
			endcase
		end
		if ($urandom_range(0, 19) == 0) s.push_back(CH_DOT);
		// Damage: overwrite or insert one stray byte
		if ($urandom_range(0, 7) == 0) begin
			junk = char_t'($urandom_range(1, 255));
			pos = $urandom_range(0, s.size());
			if (s.size() != 0 && $urandom_range(0, 1)) s[pos % s.size()] = junk;
			else s.insert(pos, junk);
		end
		push_string(s);
	endtask

	initial begin
		char_t s[$];
		clear_string();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct <= 0;
					recv_stall_pct <= 0;
				end
				1: begin
					send_idle_pct <= 71;
					recv_stall_pct <= 0;
				end
				2: begin
					send_idle_pct <= 0;
					recv_stall_pct <= 71;
				end
				default: begin
					send_idle_pct <= 11;
					recv_stall_pct <= 11;
				end
			endcase
			if (ph == 0) begin
				// Empty string, mixed radices with sign and empty part,
				// large part, hex prefix without digit, top byte value
				load_text("");
				load_text("\t+0xFf..-0.0377");
				load_text("256");
				load_text("0x");
				s.push_back(char_t'(8'hFF));
				push_string(s);
			end
			while (n_chars < (ph + 1) * PHASE_CHARS) emit_string();
			// Hold off until the phase has fully drained
			while (char_q.size() != 0 || ch_valid || parse_q.size() != 0)
				@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d characters in %0d strings over four idle/stall phases;",
			n_chars, n_strings);
		$display("checked %0d parses accepted and %0d rejected, %0d mismatches.",
			n_ok, n_bad, errors);
		if (errors == 0 && parse_q.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
